// File: sv/console_line_editor_assert.svh
// Assertion macros used by the console line editor datapath.
`ifndef CONSOLE_LINE_EDITOR_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("console line editor: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define CLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("console line editor: next-cycle check failed");

`endif

// File: sv/cle_pkg.sv
// Types, codes and constants of the console line editor.
`default_nettype none
package cle_pkg;

	// Line storage size and fixed field widths
	localparam int LINE_SIZE_DEF = 64;
	localparam int CHAR_W        = 8;
	localparam int LINE_LEN_W    = 6;
	localparam int KIND_W        = 2;
	localparam int CFG_IDX_W     = 3;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

	// Register reset values
	localparam logic [CHAR_W-1:0] ESCAPE_RST    = 8'd27;
	localparam logic [CHAR_W-1:0] RETURN_RST    = 8'd13;
	localparam logic [CHAR_W-1:0] RECALL_RST    = 8'd16;
	localparam logic [CHAR_W-1:0] BACKSPACE_RST = 8'd8;
	localparam logic [CHAR_W-1:0] DELETE_RST    = 8'd127;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ESCAPE    = 3'd0,
		CFG_RETURN    = 3'd1,
		CFG_RECALL    = 3'd2,
		CFG_BACKSPACE = 3'd3,
		CFG_DELETE    = 3'd4
	} cfg_idx_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_BYTE,
		ST_END
	} state_t;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_ESC,
		OP_RET,
		OP_REC,
		OP_BS,
		OP_BACK,
		OP_CHR,
		OP_READ,
		OP_BYTE,
		OP_END
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic is_zero;
		logic is_esc;
		logic is_rec;
		logic is_bs;
		logic is_ret;
		logic pos_zero;
		logic hist_zero;
		logic out_free;
		logic idx_last;
		logic rec_mode;
	} stat_t;

endpackage
`default_nettype wire

// File: sv/cle_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, hold when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: sv/cle_ctrl.sv
// Controller state machine of the console line editor.
`default_nettype none
module cle_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output      logic           in_stall,
	input  wire cle_pkg::stat_t stat,
	output      cle_pkg::cmd_t  cmd
);

	import cle_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.is_zero) begin
					state_d = ST_IDLE;
				end else if (stat.is_esc) begin
					state_d = stat.pos_zero ? ST_END : ST_READ;
				end else if (stat.is_rec) begin
					state_d = stat.hist_zero ? ST_IDLE : ST_READ;
				end else if (stat.is_bs) begin
					if (stat.is_ret || stat.out_free) begin
						state_d = ST_IDLE;
					end
				end else if (stat.is_ret) begin
					state_d = stat.pos_zero ? ST_END : ST_READ;
				end else if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				state_d = ST_BYTE;
			end
			ST_BYTE: begin
				if (stat.out_free) begin
					if (!stat.idx_last) begin
						state_d = ST_READ;
					end else begin
						state_d = stat.rec_mode ? ST_IDLE : ST_END;
					end
				end
			end
			ST_END: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd.op   = OP_NONE;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op = OP_CAPTURE;
				end
			end
			ST_DECODE: begin
				if (stat.is_zero) begin
					cmd.op = OP_NONE;
				end else if (stat.is_esc) begin
					cmd.op = OP_ESC;
				end else if (stat.is_rec) begin
					cmd.op = OP_REC;
				end else if (stat.is_bs) begin
					// a backspace or delete byte that is also the return byte steps back without echo
					if (stat.is_ret) begin
						cmd.op = OP_BACK;
					end else if (stat.out_free) begin
						cmd.op = OP_BS;
					end
				end else if (stat.is_ret) begin
					cmd.op = OP_RET;
				end else if (stat.out_free) begin
					cmd.op = OP_CHR;
				end
			end
			ST_READ: begin
				cmd.op = OP_READ;
			end
			ST_BYTE: begin
				if (stat.out_free) begin
					cmd.op = OP_BYTE;
				end
			end
			ST_END: begin
				if (stat.out_free) begin
					cmd.op = OP_END;
				end
			end
			default: begin
				cmd.op = OP_NONE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: sv/cle_datapath.sv
// Datapath of the console line editor: registers, line stores, result register.
`default_nettype none
module cle_datapath #(
	parameter int LINE_SIZE = cle_pkg::LINE_SIZE_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [cle_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [cle_pkg::CHAR_W-1:0]        cfg_data,
	input  wire logic [cle_pkg::CHAR_W-1:0]        char_in,
	input  wire cle_pkg::cmd_t                     cmd,
	output      cle_pkg::stat_t                    stat,
	output      logic                              out_valid,
	input  wire logic                              out_stall,
	output      logic [cle_pkg::KIND_W-1:0]        kind,
	output      logic [cle_pkg::CHAR_W-1:0]        data_byte,
	output      logic [cle_pkg::LINE_LEN_W-1:0]    line_length,
	output      logic                              by_escape,
	output      logic                              last
);

	import cle_pkg::*;

	localparam int AW = $clog2(LINE_SIZE);
	localparam int PW = $clog2(LINE_SIZE + 1);
	localparam logic [PW-1:0] POS_MAX = PW'(LINE_SIZE - 1);

	logic [CHAR_W-1:0] esc_code_q, ret_code_q, rec_code_q, bs_code_q, del_code_q;
	logic [CHAR_W-1:0] char_q;
	logic [PW-1:0]     pos_q;
	logic [AW-1:0]     hist_len_q;
	logic [AW-1:0]     len_q;
	logic [AW-1:0]     idx_q;
	logic              esc_q;
	logic              rec_q;

	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [CHAR_W-1:0] data_q;
	logic [LINE_LEN_W-1:0] len_out_q;
	logic              by_esc_q;
	logic              last_q;

	logic [PW-1:0]     pos_eff;
	logic              out_free;
	logic              out_load;
	logic              line_we, hist_we, rd_en;
	logic [AW-1:0]     line_waddr;
	logic [CHAR_W-1:0] line_wdata;
	logic [CHAR_W-1:0] line_rdata, hist_rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_code_q <= ESCAPE_RST;
			ret_code_q <= RETURN_RST;
			rec_code_q <= RECALL_RST;
			bs_code_q  <= BACKSPACE_RST;
			del_code_q <= DELETE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_ESCAPE:    esc_code_q <= cfg_data;
				CFG_RETURN:    ret_code_q <= cfg_data;
				CFG_RECALL:    rec_code_q <= cfg_data;
				CFG_BACKSPACE: bs_code_q  <= cfg_data;
				CFG_DELETE:    del_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Wrap a position past the last slot, free the result register
	assign pos_eff  = (pos_q > POS_MAX) ? '0 : pos_q;
	assign out_free = !out_valid_q || !out_stall;

	// Status toward the controller
	always_comb begin
		stat.is_zero   = (char_q == '0);
		stat.is_esc    = (char_q == esc_code_q);
		stat.is_rec    = (char_q == rec_code_q);
		stat.is_bs     = (char_q == bs_code_q) || (char_q == del_code_q);
		stat.is_ret    = (char_q == ret_code_q);
		stat.pos_zero  = (pos_eff == '0);
		stat.hist_zero = (hist_len_q == '0);
		stat.out_free  = out_free;
		stat.idx_last  = (idx_q == AW'(len_q - AW'(1)));
		stat.rec_mode  = rec_q;
	end

	// Line state and walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			hist_len_q <= '0;
			len_q      <= '0;
			idx_q      <= '0;
			esc_q      <= 1'b0;
			rec_q      <= 1'b0;
		end else begin
			case (cmd.op) inside
				OP_ESC: begin
					len_q <= pos_eff[AW-1:0];
					pos_q <= '0;
					idx_q <= '0;
					esc_q <= 1'b1;
					rec_q <= 1'b0;
				end
				OP_RET: begin
					len_q      <= pos_eff[AW-1:0];
					hist_len_q <= pos_eff[AW-1:0];
					pos_q      <= '0;
					idx_q      <= '0;
					esc_q      <= 1'b0;
					rec_q      <= 1'b0;
				end
				OP_REC: begin
					len_q <= hist_len_q;
					pos_q <= PW'(hist_len_q);
					idx_q <= '0;
					esc_q <= 1'b0;
					rec_q <= 1'b1;
				end
				OP_BS, OP_BACK: begin
					pos_q <= (pos_eff == '0) ? '0 : PW'(pos_eff - PW'(1));
				end
				OP_CHR: begin
					pos_q <= PW'(pos_eff + PW'(1));
				end
				OP_BYTE: begin
					idx_q <= AW'(idx_q + AW'(1));
				end
				default: ;
			endcase
		end
	end

	// Capture the received character
	always_ff @(posedge clk) begin
		if (cmd.op == OP_CAPTURE) begin
			char_q <= char_in;
		end
	end

	// Store port controls
	assign rd_en      = (cmd.op == OP_READ);
	assign line_we    = (cmd.op == OP_CHR) || ((cmd.op == OP_BYTE) && rec_q);
	assign line_waddr = (cmd.op == OP_CHR) ? pos_eff[AW-1:0] : idx_q;
	assign line_wdata = (cmd.op == OP_CHR) ? char_q : hist_rdata;
	assign hist_we    = (cmd.op == OP_BYTE) && !rec_q && !esc_q;

	cle_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(LINE_SIZE)
	) u_line_ram (
		.clk  (clk),
		.we   (line_we),
		.waddr(line_waddr),
		.wdata(line_wdata),
		.re   (rd_en),
		.raddr(idx_q),
		.rdata(line_rdata)
	);

	cle_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(LINE_SIZE)
	) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.waddr(idx_q),
		.wdata(line_rdata),
		.re   (rd_en),
		.raddr(idx_q),
		.rdata(hist_rdata)
	);

	// Load a result on echo, line byte or line end
	assign out_load = (cmd.op == OP_BS) || (cmd.op == OP_CHR) ||
	                  (cmd.op == OP_BYTE) || (cmd.op == OP_END);

	// Result valid: set on load, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		case (cmd.op) inside
			OP_BS, OP_CHR: begin
				kind_q    <= KIND_ECHO;
				data_q    <= char_q;
				len_out_q <= '0;
				by_esc_q  <= 1'b0;
				last_q    <= 1'b1;
			end
			OP_BYTE: begin
				kind_q    <= rec_q ? KIND_ECHO : KIND_LINE;
				data_q    <= rec_q ? hist_rdata : line_rdata;
				len_out_q <= '0;
				by_esc_q  <= esc_q;
				last_q    <= rec_q && stat.idx_last;
			end
			OP_END: begin
				kind_q    <= KIND_END;
				data_q    <= '0;
				len_out_q <= LINE_LEN_W'(len_q);
				by_esc_q  <= esc_q;
				last_q    <= 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign data_byte   = data_q;
	assign line_length = len_out_q;
	assign by_escape   = by_esc_q;
	assign last        = last_q;

	`include "console_line_editor_assert.svh"

	// Load a result only into a free register
	`CLE_ASSERT_NOW(a_load_free, clk, arst_n, out_load, out_free)
	// Walk stays inside the line
	`CLE_ASSERT_NOW(a_walk_range, clk, arst_n, (cmd.op == OP_READ) || (cmd.op == OP_BYTE), idx_q < len_q)
	// A stored character advances the wrapped position by one
	`CLE_ASSERT_NEXT(a_chr_advance, clk, arst_n, cmd.op == OP_CHR, pos_q == PW'($past(pos_eff) + PW'(1)))

endmodule
`default_nettype wire

// File: sv/console_line_editor.sv
// Top level of the console line editor: controller and datapath.
//
// Input channel: char_in with in_valid / in_stall; one received byte per
// transfer, a zero byte is dropped. Output channel: kind, data_byte,
// line_length, by_escape and last with out_valid / out_stall; last marks the
// final result of one input byte. Configuration: cfg_write, cfg_index and
// cfg_data load the escape, return, recall, backspace and delete codes.
// An ordinary byte or a backspace loads its echo into the result register
// from the decode state, which waits for a free result register; the idle
// state after it takes the next byte. Escape and return walk the line store,
// recall walks the history store: each stored byte passes a read state and a
// byte state through the registered read port of the store, and escape and
// return end with a line end event. A line holds at most LINE_SIZE - 1 bytes.
// The next byte is taken once the previous one has loaded its final result,
// or has been decoded if it has none; that result may still wait in the
// output register. A stalled receiver holds the walk in place.
// Reset clears the position and history length and loads the default codes;
// the store contents are not cleared and need no clearing pass.
`default_nettype none
module console_line_editor #(
	parameter int LINE_SIZE = cle_pkg::LINE_SIZE_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [cle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cle_pkg::CHAR_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output      logic                           in_stall,
	input  wire logic [cle_pkg::CHAR_W-1:0]     char_in,
	output      logic                           out_valid,
	input  wire logic                           out_stall,
	output      logic [cle_pkg::KIND_W-1:0]     kind,
	output      logic [cle_pkg::CHAR_W-1:0]     data_byte,
	output      logic [cle_pkg::LINE_LEN_W-1:0] line_length,
	output      logic                           by_escape,
	output      logic                           last
);

	import cle_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequence each byte
	cle_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	// Hold line state, stores and the result register
	cle_datapath #(
		.LINE_SIZE(LINE_SIZE)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.char_in    (char_in),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.line_length(line_length),
		.by_escape  (by_escape),
		.last       (last)
	);

endmodule
`default_nettype wire

// File: test/tb_console_line_editor.sv
// Self-checking testbench for the console line editor: directed table, then random lines.
module tb_console_line_editor;
	timeunit 1ns;
	timeprecision 1ps;
	import cle_pkg::*;

	localparam int LINE_SIZE    = LINE_SIZE_DEF;
	// longest walk of the block plus margin
	localparam int DRAIN_CYCLES = 2 * LINE_SIZE + 12;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 20;
	localparam int MAX_REPORTS  = 10;

	// code sets, by index into CODE_SETS
	localparam int SET_DEFAULT = 0;
	localparam int SET_OVERLAP = 1;
	localparam int SET_HIGH    = 2;
	localparam int SET_ZERO    = 3;
	localparam int SET_MIXED   = 4;
	localparam int NUM_SETS    = 5;

	// overlapping codes: return doubles as delete, recall doubles as backspace
	localparam logic [CHAR_W-1:0] OV_ESC = 8'h41;
	localparam logic [CHAR_W-1:0] OV_REC = 8'h42;
	localparam logic [CHAR_W-1:0] OV_RET = 8'h43;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [CHAR_W-1:0]     data;
		logic [LINE_LEN_W-1:0] len;
		logic                  esc;
		logic                  last;
	} console_out_t;

	typedef struct packed {
		logic [CHAR_W-1:0] esc;
		logic [CHAR_W-1:0] ret;
		logic [CHAR_W-1:0] rec;
		logic [CHAR_W-1:0] bs;
		logic [CHAR_W-1:0] del;
	} code_set_t;

	// ROW_PREDICT: check against the predictor; ROW_NONE / ROW_ONE: typed-in result
	typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_ONE, ROW_CODES} row_kind_t;

	typedef struct packed {
		row_kind_t         rk;
		logic [CHAR_W-1:0] c;
		console_out_t      typed;
	} stim_row_t;

	localparam console_out_t NO_OUT = '0;

	localparam code_set_t CODE_SETS [NUM_SETS] = '{
		'{ESCAPE_RST, RETURN_RST, RECALL_RST, BACKSPACE_RST, DELETE_RST},
		'{OV_ESC, OV_RET, OV_REC, OV_REC, OV_RET},
		'{8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h01, 8'hFF, 8'h80, 8'h7F, 8'h02}
	};

	localparam int PHASE_ORDER [NUM_SETS] = '{SET_HIGH, SET_MIXED, SET_OVERLAP, SET_ZERO,
		SET_DEFAULT};

	localparam int NUM_DIRECTED = 22;
	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		'{ROW_ONE, 8'h41, '{KIND_ECHO, 8'h41, 6'd0, 1'b0, 1'b1}},
		'{ROW_NONE, 8'h00, NO_OUT},
		'{ROW_PREDICT, BACKSPACE_RST, NO_OUT},
		// backspace at the start of the line: echo only
		'{ROW_ONE, BACKSPACE_RST, '{KIND_ECHO, BACKSPACE_RST, 6'd0, 1'b0, 1'b1}},
		// empty line ended by return, then by escape
		'{ROW_ONE, RETURN_RST, '{KIND_END, 8'h00, 6'd0, 1'b0, 1'b1}},
		'{ROW_NONE, RECALL_RST, NO_OUT},
		'{ROW_ONE, ESCAPE_RST, '{KIND_END, 8'h00, 6'd0, 1'b1, 1'b1}},
		'{ROW_ONE, 8'hFF, '{KIND_ECHO, 8'hFF, 6'd0, 1'b0, 1'b1}},
		'{ROW_ONE, 8'h01, '{KIND_ECHO, 8'h01, 6'd0, 1'b0, 1'b1}},
		'{ROW_PREDICT, DELETE_RST, NO_OUT},
		'{ROW_PREDICT, 8'h42, NO_OUT},
		'{ROW_PREDICT, 8'h43, NO_OUT},
		'{ROW_PREDICT, RETURN_RST, NO_OUT},
		'{ROW_PREDICT, RECALL_RST, NO_OUT},
		'{ROW_PREDICT, ESCAPE_RST, NO_OUT},
		'{ROW_CODES, 8'(SET_OVERLAP), NO_OUT},
		'{ROW_PREDICT, 8'h5A, NO_OUT},
		'{ROW_PREDICT, 8'h59, NO_OUT},
		'{ROW_PREDICT, OV_RET, NO_OUT},
		'{ROW_PREDICT, OV_REC, NO_OUT},
		'{ROW_PREDICT, OV_ESC, NO_OUT},
		'{ROW_CODES, 8'(SET_DEFAULT), NO_OUT}
	};

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  cfg_write   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CHAR_W-1:0]     cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [CHAR_W-1:0]     char_in     = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [KIND_W-1:0]     kind;
	logic [CHAR_W-1:0]     data_byte;
	logic [LINE_LEN_W-1:0] line_length;
	logic                  by_escape;
	logic                  last;

	// editor state as predicted
	code_set_t         codes;
	logic [CHAR_W-1:0] line_mem [LINE_SIZE];
	logic [CHAR_W-1:0] hist_mem [LINE_SIZE];
	logic [6:0]        cur_pos;
	logic [5:0]        hist_len;

	console_out_t pending_out [$];
	console_out_t step_out [$];
	int           mismatches  = 0;
	int           stall_left  = 0;
	int           items_sent  = 0;
	int           cycle_count = 0;
	bit           quiet       = 1'b0;

	console_line_editor #(.LINE_SIZE(LINE_SIZE)) uut (
		.clk, .arst_n, .cfg_write, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .char_in,
		.out_valid, .out_stall, .kind, .data_byte, .line_length, .by_escape, .last
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// bail out on a hang
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_console_line_editor: FAIL");
			$finish;
		end
	end

	task automatic push_out(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] d,
			input logic [LINE_LEN_W-1:0] len, input logic esc);
		step_out.push_back('{k, d, len, esc, 1'b0});
	endtask

	task automatic emit_line(input logic esc);
		for (int i = 0; i < cur_pos[5:0]; i++)
			push_out(KIND_LINE, line_mem[i], '0, esc);
		push_out(KIND_END, '0, cur_pos[5:0], esc);
	endtask

	// predict the results of one received byte into step_out
	task automatic edit_char(input logic [CHAR_W-1:0] c);
		step_out.delete();
		if (c == '0)
			return;
		if (cur_pos > 7'(LINE_SIZE - 1))
			cur_pos = '0;
		if (c != codes.esc && c != codes.ret && c != codes.rec)
			push_out(KIND_ECHO, c, '0, 1'b0);
		if (c == codes.esc) begin
			emit_line(1'b1);
			cur_pos = '0;
		end else if (c == codes.rec) begin
			cur_pos = {1'b0, hist_len};
			for (int i = 0; i < hist_len; i++) begin
				line_mem[i] = hist_mem[i];
				push_out(KIND_ECHO, line_mem[i], '0, 1'b0);
			end
		end else if (c == codes.bs || c == codes.del) begin
			if (cur_pos != '0)
				cur_pos--;
		end else if (c == codes.ret) begin
			hist_len = cur_pos[5:0];
			for (int i = 0; i < hist_len; i++)
				hist_mem[i] = line_mem[i];
			emit_line(1'b0);
			cur_pos = '0;
		end else begin
			line_mem[cur_pos[5:0]] = c;
			cur_pos++;
		end
		if (step_out.size() != 0)
			step_out[$].last = 1'b1;
	endtask

	// transfer one byte and queue what it should produce
	task automatic send_char(input logic [CHAR_W-1:0] c, input row_kind_t rk,
			input console_out_t typed);
		int gap;
		if ($urandom_range(0, 29) == 0)
			quiet = !quiet;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in  <= c;
		do @(posedge clk); while (in_stall);
		edit_char(c);
		case (rk)
			ROW_ONE: pending_out.push_back(typed);
			ROW_NONE: ;
			default: foreach (step_out[i]) pending_out.push_back(step_out[i]);
		endcase
		if (c != '0)
			items_sent++;
	endtask

	// hold the input until every result is out and the block has gone quiet
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_code(input cfg_idx_t idx, input logic [CHAR_W-1:0] v);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		case (idx)
			CFG_ESCAPE:    codes.esc = v;
			CFG_RETURN:    codes.ret = v;
			CFG_RECALL:    codes.rec = v;
			CFG_BACKSPACE: codes.bs  = v;
			CFG_DELETE:    codes.del = v;
			default: ;
		endcase
	endtask

	task automatic load_codes(input int set);
		write_code(CFG_ESCAPE, CODE_SETS[set].esc);
		write_code(CFG_RETURN, CODE_SETS[set].ret);
		write_code(CFG_RECALL, CODE_SETS[set].rec);
		write_code(CFG_BACKSPACE, CODE_SETS[set].bs);
		write_code(CFG_DELETE, CODE_SETS[set].del);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [CHAR_W-1:0] pick_plain();
		logic [CHAR_W-1:0] c;
		do c = CHAR_W'($urandom_range(1, 255));
		while (c == codes.esc || c == codes.ret || c == codes.rec || c == codes.bs
			|| c == codes.del);
		return c;
	endfunction

	// type a line, with optional edits, and end it
	task automatic send_line(input int len, input logic [CHAR_W-1:0] ender, input bit edits);
		for (int i = 0; i < len; i++) begin
			if (edits && $urandom_range(0, 5) == 0)
				send_char($urandom_range(0, 1) ? codes.bs : codes.del, ROW_PREDICT, NO_OUT);
			else
				send_char(pick_plain(), ROW_PREDICT, NO_OUT);
		end
		send_char(ender, ROW_PREDICT, NO_OUT);
	endtask

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		console_out_t got;
		console_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{kind, data_byte, line_length, by_escape, last};
			if (pending_out.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: kind %0d data %02h len %0d esc %0b last %0b",
						got.kind, got.data, got.len, got.esc, got.last);
			end else begin
				want = pending_out.pop_front();
				if (got.kind !== want.kind || got.data !== want.data || got.len !== want.len
						|| got.esc !== want.esc || got.last !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$write("mismatch: expected kind %0d data %02h len %0d esc %0b last %0b,",
							want.kind, want.data, want.len, want.esc, want.last);
						$display(" got kind %0d data %02h len %0d esc %0b last %0b",
							got.kind, got.data, got.len, got.esc, got.last);
					end
				end
			end
			stall_left = quiet ? 0 : $urandom_range(0, 4);
		end else if (stall_left != 0) begin
			stall_left--;
		end
		out_stall <= (stall_left != 0);
	end

	initial begin
		int set;
		int phase_start;
		int pick;
		bit paused;
		codes    = CODE_SETS[SET_DEFAULT];
		cur_pos  = '0;
		hist_len = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		for (int r = 0; r < NUM_DIRECTED; r++) begin
			if (DIRECTED[r].rk == ROW_CODES) begin
				wait_drained();
				load_codes(int'(DIRECTED[r].c));
			end else begin
				send_char(DIRECTED[r].c, DIRECTED[r].rk, DIRECTED[r].typed);
			end
		end

		// random phases, one per code set
		for (int p = 0; p < NUM_SETS; p++) begin
			set = PHASE_ORDER[p];
			wait_drained();
			load_codes(set);
			if (set == SET_DEFAULT) begin
				// longest line, its recall, then fill the line and wrap
				send_line(LINE_SIZE - 1, codes.ret, 1'b0);
				send_char(codes.rec, ROW_PREDICT, NO_OUT);
				send_line(2, codes.ret, 1'b0);
			end
			phase_start = items_sent;
			paused = 1'b0;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if (!paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
					wait_drained();
					paused = 1'b1;
				end
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					case ($urandom_range(0, 3))
						0, 1: send_line(($urandom_range(0, 15) == 0) ? $urandom_range(60, 70)
							: $urandom_range(0, 10), codes.ret, 1'b1);
						2: send_line($urandom_range(0, 10), codes.esc, 1'b1);
						default: send_line($urandom_range(0, 10), codes.rec, 1'b1);
					endcase
				end else begin
					send_char(CHAR_W'($urandom_range(0, 255)), ROW_PREDICT, NO_OUT);
				end
			end
		end

		wait_drained();
		if (mismatches == 0)
			$display("tb_console_line_editor: PASS");
		else
			$display("tb_console_line_editor: FAIL");
		$finish;
	end

endmodule
